### rtl/fto_pkg.sv
// Five-tuple owner table: shared types and constants.
// Holds the item structs, the table entry layout and the table geometry.
// No dependencies.
package fto_pkg;

    // Table geometry
    localparam int unsigned TABLE_ENTRIES = 2048;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Address family codes
    localparam logic [1:0] FAMILY_IPV4 = 2'd1;
    localparam logic [1:0] FAMILY_IPV6 = 2'd2;

    // Input item
    typedef struct packed {
        logic        operation;
        logic [1:0]  address_family;
        logic [63:0] local_addr_hi;
        logic [63:0] local_addr_lo;
        logic [15:0] local_port;
        logic [63:0] remote_addr_hi;
        logic [63:0] remote_addr_lo;
        logic [15:0] remote_port;
        logic [31:0] owner_id;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [31:0] found_owner;
        logic        hit;
    } out_item_t;

    // One table slot as stored in memory
    typedef struct packed {
        logic [1:0]  family;
        logic [63:0] local_hi;
        logic [63:0] local_lo;
        logic [15:0] local_port;
        logic [63:0] remote_hi;
        logic [63:0] remote_lo;
        logic [15:0] remote_port;
        logic [31:0] owner;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

### rtl/fto_ram.sv
// Five-tuple owner table: generic simple dual-port RAM.
// One write port, one read port with registered read data.
// No dependencies.
module fto_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/five_tuple_owner_table_core.sv
// Five-tuple owner table: top level with scan sequencer and output register.
// Depends on fto_pkg and fto_ram.
//
// Maps a connection five-tuple to a 32-bit owner id in a table of
// TABLE_ENTRIES slots held in one single-port-read memory. Every item gives
// one result. Slots fill in order from slot 0, so a fill count marks the
// written slots and no clearing pass is needed after reset. An item is
// scanned one slot per cycle, in slot order, up to the first match or the
// fill count, at most TABLE_ENTRIES slots with a full table. An ignored
// record or a lookup while lookups are disabled skips the scan. The scan
// rate is set by the one memory read port. One item is worked on at a
// time; a new item is taken while the previous result waits in the output
// register.
module five_tuple_owner_table_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  fto_pkg::in_item_t s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output fto_pkg::out_item_t m_item
);

    import fto_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESULT
    } state_t;

    state_t             state_reg;
    logic               lookup_enabled_reg;
    in_item_t           item_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [31:0]        hit_owner_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic               m_valid_reg;
    out_item_t          m_item_reg;

    logic               accept;
    logic               skip;
    logic               match;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_entry;
    entry_t             rd_entry;
    logic [ENTRY_W-1:0] rd_data;
    logic               out_free;

    // Slot memory
    fto_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);

    // Handshakes
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // Items that never touch the table
    assign skip = (s_item.operation == OP_LOOKUP) ? !lookup_enabled_reg
                : ((s_item.owner_id == 32'd0) ||
                   ((s_item.address_family != FAMILY_IPV4) &&
                    (s_item.address_family != FAMILY_IPV6)));

    // Compare the slot read last cycle; only slots below the fill count are
    // read, and those all hold a nonzero owner
    assign match = (rd_entry.family      == item_reg.address_family) &&
                   (rd_entry.local_hi    == item_reg.local_addr_hi) &&
                   (rd_entry.local_lo    == item_reg.local_addr_lo) &&
                   (rd_entry.local_port  == item_reg.local_port) &&
                   (rd_entry.remote_hi   == item_reg.remote_addr_hi) &&
                   (rd_entry.remote_lo   == item_reg.remote_addr_lo) &&
                   (rd_entry.remote_port == item_reg.remote_port);

    // Read address: slot 0 at accept, then the next slot while scanning
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = rd_idx_reg[IDX_W-1:0];
        if (state_reg == ST_IDLE) begin
            if (accept && !skip && (fill_reg != CNT_W'(0))) begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
        end else if (state_reg == ST_SCAN) begin
            if (!match && (rd_idx_reg < fill_reg)) begin
                rd_en = 1'b1;
            end
        end
    end

    // Write back: matched slot, else the slot under the replace pointer
    always_comb begin
        wr_en                = (state_reg == ST_DECIDE) && (item_reg.operation == OP_RECORD);
        wr_addr              = hit_reg ? hit_idx_reg : ptr_reg;
        wr_entry.family      = item_reg.address_family;
        wr_entry.local_hi    = item_reg.local_addr_hi;
        wr_entry.local_lo    = item_reg.local_addr_lo;
        wr_entry.local_port  = item_reg.local_port;
        wr_entry.remote_hi   = item_reg.remote_addr_hi;
        wr_entry.remote_lo   = item_reg.remote_addr_lo;
        wr_entry.remote_port = item_reg.remote_port;
        wr_entry.owner       = item_reg.owner_id;
    end

    // Sequencer, table pointers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            lookup_enabled_reg <= 1'b0;
            ptr_reg            <= '0;
            fill_reg           <= '0;
            m_valid_reg        <= 1'b0;
            hit_reg            <= 1'b0;
        end else begin
            if (cfg_we) begin
                lookup_enabled_reg <= cfg_wdata;
            end
            // the result state reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != ST_RESULT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        item_reg    <= s_item;
                        hit_reg     <= 1'b0;
                        rd_idx_reg  <= CNT_W'(1);
                        cmp_idx_reg <= '0;
                        if (skip) begin
                            state_reg <= ST_RESULT;
                        end else if (fill_reg == CNT_W'(0)) begin
                            state_reg <= ST_DECIDE;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (match) begin
                        hit_reg       <= 1'b1;
                        hit_idx_reg   <= cmp_idx_reg;
                        hit_owner_reg <= rd_entry.owner;
                        state_reg     <= ST_DECIDE;
                    end else if (rd_idx_reg < fill_reg) begin
                        cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
                        rd_idx_reg  <= rd_idx_reg + CNT_W'(1);
                    end else begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (wr_en) begin
                        if (wr_addr == ptr_reg) begin
                            ptr_reg <= (ptr_reg == IDX_W'(TABLE_ENTRIES - 1)) ?
                                       '0 : ptr_reg + IDX_W'(1);
                        end
                        if (CNT_W'(wr_addr) == fill_reg) begin
                            fill_reg <= fill_reg + CNT_W'(1);
                        end
                    end
                    state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if ((item_reg.operation == OP_LOOKUP) && hit_reg) begin
                            m_item_reg.found_owner <= hit_owner_reg;
                            m_item_reg.hit         <= 1'b1;
                        end else begin
                            m_item_reg.found_owner <= 32'd0;
                            m_item_reg.hit         <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // Fill count never passes the table size
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    // Until the table is full, the replace pointer sits at the fill count
    a_ptr_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != CNT_W'(TABLE_ENTRIES)) |-> (CNT_W'(ptr_reg) == fill_reg))
        else $error("replace pointer away from fill count");

    // Scan reads stay inside the written slots
    a_read_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (CNT_W'(rd_addr) < fill_reg))
        else $error("read of unwritten slot");

    // A write lands on a written slot or the next free one
    a_write_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (CNT_W'(wr_addr) <= fill_reg))
        else $error("write beyond fill count");

    // One item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second item taken while busy");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for five_tuple_owner_table_core: a directed table, then random
// flows, checked item by item against an in-bench owner-table predictor.
// Depends on fto_pkg and the RTL of the core.
module tb_top;
    import fto_pkg::*;

    typedef enum logic {ROW_ITEM, ROW_SET_ENABLE} dir_kind_e;

    typedef struct {
        dir_kind_e kind;
        logic      enable;
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // Shadow of the table, replacement pointer and enable
    entry_t           slot_shadow [TABLE_ENTRIES];
    logic [IDX_W-1:0] replace_ptr_shadow;
    logic             lookup_en_shadow;

    out_item_t   owner_expect_q [$];
    in_item_t    flow_pool [$];
    dir_row_t    dir_rows [$];
    int unsigned mismatch_count = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          hold_req = 1'b0;

    five_tuple_owner_table_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: covers roughly 300 items, each with a full scan and both idle
    // bursts, with room to spare.
    initial begin
        #10000000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Owner table behavior: first valid match wins, new tuples go to the pointer
    function automatic out_item_t predict_owner(in_item_t it);
        out_item_t   res;
        int unsigned slot;
        bit          matched;
        res = '0;
        matched = 1'b0;
        slot = replace_ptr_shadow;
        if (it.operation == OP_LOOKUP && !lookup_en_shadow) return res;
        if (it.operation == OP_RECORD && (it.owner_id == '0 ||
            (it.address_family != FAMILY_IPV4 && it.address_family != FAMILY_IPV6)))
            return res;
        for (int i = 0; i < TABLE_ENTRIES && !matched; i++) begin
            if (slot_shadow[i].owner != '0 &&
                slot_shadow[i].family == it.address_family &&
                slot_shadow[i].local_hi == it.local_addr_hi &&
                slot_shadow[i].local_lo == it.local_addr_lo &&
                slot_shadow[i].local_port == it.local_port &&
                slot_shadow[i].remote_hi == it.remote_addr_hi &&
                slot_shadow[i].remote_lo == it.remote_addr_lo &&
                slot_shadow[i].remote_port == it.remote_port) begin
                slot = i;
                matched = 1'b1;
            end
        end
        if (it.operation == OP_LOOKUP) begin
            if (matched) begin
                res.found_owner = slot_shadow[slot].owner;
                res.hit = 1'b1;
            end
            return res;
        end
        if (slot == replace_ptr_shadow) replace_ptr_shadow = replace_ptr_shadow + 1'b1;
        slot_shadow[slot].family      = it.address_family;
        slot_shadow[slot].local_hi    = it.local_addr_hi;
        slot_shadow[slot].local_lo    = it.local_addr_lo;
        slot_shadow[slot].local_port  = it.local_port;
        slot_shadow[slot].remote_hi   = it.remote_addr_hi;
        slot_shadow[slot].remote_lo   = it.remote_addr_lo;
        slot_shadow[slot].remote_port = it.remote_port;
        slot_shadow[slot].owner       = it.owner_id;
        return res;
    endfunction

    function automatic logic [63:0] rand_word64();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic in_item_t fresh_tuple();
        in_item_t t;
        t.operation      = OP_RECORD;
        t.address_family = $urandom_range(0, 1) ? FAMILY_IPV4 : FAMILY_IPV6;
        t.local_addr_hi  = rand_word64();
        t.local_addr_lo  = rand_word64();
        t.local_port     = 16'($urandom);
        t.remote_addr_hi = rand_word64();
        t.remote_addr_lo = rand_word64();
        t.remote_port    = 16'($urandom);
        t.owner_id       = $urandom_range(32'hFFFF_FFFF, 1);
        return t;
    endfunction

    // Mostly records and lookups of known flows; the rest is noise
    function automatic in_item_t random_flow_item();
        in_item_t    it;
        int unsigned roll;
        int unsigned pick;
        int unsigned bitpos;
        roll = $urandom_range(0, 99);
        if (flow_pool.size() == 0) roll = 0;
        pick = (flow_pool.size() == 0) ? 0 : $urandom_range(0, flow_pool.size() - 1);
        bitpos = $urandom_range(0, 63);
        if (roll < 20) begin
            it = fresh_tuple();
            flow_pool.push_back(it);
            if (flow_pool.size() > 48) void'(flow_pool.pop_front());
        end else if (roll < 38) begin
            it = flow_pool[pick];
            it.operation = OP_RECORD;
            it.owner_id = $urandom_range(32'hFFFF_FFFF, 1);
        end else if (roll < 75) begin
            it = flow_pool[pick];
            it.operation = OP_LOOKUP;
            it.owner_id = $urandom;
        end else if (roll < 85) begin
            // near miss: one bit of an address or port flipped, or the family swapped
            it = flow_pool[pick];
            it.operation = OP_LOOKUP;
            case ($urandom_range(0, 6))
                0: it.local_addr_hi[bitpos]       = ~it.local_addr_hi[bitpos];
                1: it.local_addr_lo[bitpos]       = ~it.local_addr_lo[bitpos];
                2: it.local_port[bitpos % 16]     = ~it.local_port[bitpos % 16];
                3: it.remote_addr_hi[bitpos]      = ~it.remote_addr_hi[bitpos];
                4: it.remote_addr_lo[bitpos]      = ~it.remote_addr_lo[bitpos];
                5: it.remote_port[bitpos % 16]    = ~it.remote_port[bitpos % 16];
                default: it.address_family        = it.address_family ^ 2'b11;
            endcase
        end else if (roll < 91) begin
            it = flow_pool[pick];
            it.operation = OP_RECORD;
            it.owner_id = '0;
        end else if (roll < 96) begin
            it = flow_pool[pick];
            it.operation = $urandom_range(0, 1) ? OP_LOOKUP : OP_RECORD;
            it.address_family = $urandom_range(0, 1) ? 2'd0 : 2'd3;
            it.owner_id = $urandom;
        end else begin
            it = fresh_tuple();
            it.operation = $urandom_range(0, 1) ? OP_LOOKUP : OP_RECORD;
            it.address_family = 2'($urandom);
            it.owner_id = $urandom;
        end
        return it;
    endfunction

    function automatic in_item_t as_item(in_item_t t, logic op, logic [31:0] owner);
        t.operation = op;
        t.owner_id = owner;
        return t;
    endfunction

    task automatic add_item_row(input in_item_t it, input logic typed,
                                input logic [31:0] owner, input logic hit);
        dir_row_t row;
        row.kind = ROW_ITEM;
        row.enable = 1'b0;
        row.item = it;
        row.typed = typed;
        row.want.found_owner = owner;
        row.want.hit = hit;
        dir_rows.push_back(row);
    endtask

    task automatic add_enable_row(input logic en);
        dir_row_t row;
        row.kind = ROW_SET_ENABLE;
        row.enable = en;
        row.item = '0;
        row.typed = 1'b0;
        row.want = '0;
        dir_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic offer_item(input in_item_t it, input logic typed, input out_item_t want);
        out_item_t predicted;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_item = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_owner(it);
        owner_expect_q.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid = 1'b0;
        while (owner_expect_q.size() != 0) @(negedge aclk);
    endtask

    // Every item gives a result, so an empty queue means the core is idle
    task automatic set_lookup_enable(input logic en);
        wait_results_drained();
        cfg_wdata = en;
        cfg_we = 1'b1;
        @(negedge aclk);
        cfg_we = 1'b0;
        lookup_en_shadow = en;
    endtask

    task automatic run_random(input int count, input bit hold_mid, input bit pause_mid,
                              input int quiet_tail);
        for (int n = 0; n < count; n++) begin
            if (n >= count - quiet_tail) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (hold_mid && n == count / 3) hold_req = 1'b1;
            if (pause_mid && n == (2 * count) / 3) wait_results_drained();
            offer_item(random_flow_item(), 1'b0, '0);
        end
    endtask

    // Result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        m_ready = 1'b0;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = 300;
                hold_req = 1'b0;
            end
            if (hold_left != 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owner_expect_q.size() == 0) begin
                report_mismatch("result with nothing expected", m_item.found_owner, '0);
            end else begin
                want = owner_expect_q.pop_front();
                if (m_item.found_owner !== want.found_owner)
                    report_mismatch("found_owner", m_item.found_owner, want.found_owner);
                if (m_item.hit !== want.hit)
                    report_mismatch("hit", 32'(m_item.hit), 32'(want.hit));
            end
        end
    end

    initial begin : stimulus
        in_item_t ta;
        in_item_t tc0;
        in_item_t tc3;
        in_item_t td;
        in_item_t td_near;
        in_item_t te;
        in_item_t te_v4;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        foreach (slot_shadow[i]) slot_shadow[i] = '0;
        replace_ptr_shadow = '0;
        lookup_en_shadow = 1'b0;

        // Directed tuples: a plain IPv4 flow, all-ones and all-zeros IPv6 flows
        ta = '0;
        ta.address_family = FAMILY_IPV4;
        ta.local_addr_lo  = 64'h0000_0000_c0a8_0001;
        ta.local_port     = 16'd80;
        ta.remote_addr_lo = 64'h0000_0000_0a00_0001;
        ta.remote_port    = 16'd50000;
        tc0 = ta;
        tc0.address_family = 2'd0;
        tc0.local_port = 16'd443;
        tc3 = tc0;
        tc3.address_family = 2'd3;
        td = '1;
        td.address_family = FAMILY_IPV6;
        td_near = td;
        td_near.remote_port = 16'hFFFE;
        te = '0;
        te.address_family = FAMILY_IPV6;
        te_v4 = te;
        te_v4.address_family = FAMILY_IPV4;

        // lookups are off after reset
        add_item_row(as_item(ta, OP_LOOKUP, '0), 1'b1, '0, 1'b0);
        add_item_row(as_item(ta, OP_RECORD, 32'hFFFF_FFFF), 1'b1, '0, 1'b0);
        add_item_row(as_item(ta, OP_LOOKUP, '0), 1'b1, '0, 1'b0);
        add_enable_row(1'b1);
        add_item_row(as_item(ta, OP_LOOKUP, '0), 1'b1, 32'hFFFF_FFFF, 1'b1);
        // owner zero and invalid families are ignored
        add_item_row(as_item(td, OP_RECORD, '0), 1'b1, '0, 1'b0);
        add_item_row(as_item(td, OP_LOOKUP, '0), 1'b1, '0, 1'b0);
        add_item_row(as_item(tc0, OP_RECORD, 32'd5), 1'b1, '0, 1'b0);
        add_item_row(as_item(tc3, OP_RECORD, 32'd6), 1'b1, '0, 1'b0);
        add_item_row(as_item(tc0, OP_LOOKUP, '0), 1'b1, '0, 1'b0);
        add_item_row(as_item(tc3, OP_LOOKUP, '0), 1'b1, '0, 1'b0);
        // field extremes, near misses, refresh of an existing flow
        add_item_row(as_item(td, OP_RECORD, 32'd1), 1'b0, '0, 1'b0);
        add_item_row(as_item(te, OP_RECORD, 32'h8000_0000), 1'b0, '0, 1'b0);
        add_item_row(as_item(td, OP_LOOKUP, '0), 1'b0, '0, 1'b0);
        add_item_row(as_item(te, OP_LOOKUP, '0), 1'b0, '0, 1'b0);
        add_item_row(as_item(td_near, OP_LOOKUP, '0), 1'b0, '0, 1'b0);
        add_item_row(as_item(te_v4, OP_LOOKUP, '0), 1'b0, '0, 1'b0);
        add_item_row(as_item(ta, OP_RECORD, 32'd7), 1'b0, '0, 1'b0);
        add_item_row(as_item(ta, OP_LOOKUP, '0), 1'b0, '0, 1'b0);
        add_item_row(as_item(ta, OP_LOOKUP, 32'h1234_5678), 1'b0, '0, 1'b0);
        add_enable_row(1'b0);
        add_item_row(as_item(td, OP_LOOKUP, '0), 1'b1, '0, 1'b0);
        add_enable_row(1'b1);
        add_item_row(as_item(td, OP_LOOKUP, '0), 1'b0, '0, 1'b0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_SET_ENABLE)
                set_lookup_enable(dir_rows[r].enable);
            else
                offer_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        end

        // random phases: enabled, disabled, enabled with a quiet tail
        run_random(110, 1'b1, 1'b1, 0);
        set_lookup_enable(1'b0);
        run_random(40, 1'b0, 1'b0, 0);
        set_lookup_enable(1'b1);
        run_random(120, 1'b0, 1'b0, 40);

        wait_results_drained();
        repeat (TABLE_ENTRIES + 8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/fto_pkg.sv
rtl/fto_ram.sv
rtl/five_tuple_owner_table_core.sv
tb/tb_top.sv
